@@ hdl/iohist_pkg.sv @@
// Package with the shared types, constants and helpers of the orientation histogram.
`default_nettype none

package iohist_pkg;

	localparam int GRAD_W = 11;
	localparam int SQ_W = 2 * GRAD_W;
	localparam int MAG_W = 15;
	localparam int SUM_W = 35;
	localparam int BIN_W = 4;
	localparam int NUM_BINS = 9;

	localparam int MAX_WIDTH_DEF = 1024;
	localparam int MAG_FRAC_BITS_DEF = 4;

	localparam logic [MAG_W-1:0] MAG_MAX = '1;

	localparam int TAN_FRAC = 32;
	localparam int THR_W = 35;
	localparam int NUM_THR = 8;
	localparam int PROD_W = GRAD_W + 1 + THR_W;
	localparam int ANGLE_CMP_W = PROD_W + 1;

	// Tangents of -70, -50, -30, -10, 10, 30, 50 and 70 degrees in Q32.
	localparam logic signed [THR_W-1:0] THRESH [NUM_THR] = '{
		-35'sd11800327048, -35'sd5118542705, -35'sd2479700524, -35'sd757318616,
		35'sd757318616, 35'sd2479700524, 35'sd5118542705, 35'sd11800327048
	};

	localparam logic [BIN_W-1:0] BIN_DOWN = 4'd0;
	localparam logic [BIN_W-1:0] BIN_FLAT = 4'd4;
	localparam logic [BIN_W-1:0] BIN_UP = 4'd8;

	typedef logic [SUM_W-1:0] iohist_sum_t;
	typedef iohist_sum_t [NUM_BINS-1:0] iohist_sums_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SQUARE,
		S_SUM,
		S_ROOT,
		S_ROUND,
		S_ACCUM,
		S_TOTAL
	} iohist_state_t;

	typedef struct packed {
		logic load;
		logic square;
		logic sum;
		logic root;
		logic round;
	} iohist_grad_ctrl_t;

	typedef struct packed {
		logic read;
		logic accum;
		logic total;
	} iohist_acc_ctrl_t;

	function automatic iohist_sum_t sat_add(input iohist_sum_t a, input iohist_sum_t b);
		logic [SUM_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[SUM_W] ? '1 : s[SUM_W-1:0];
	endfunction

endpackage

`default_nettype wire

@@ hdl/iohist_pixel_if.sv @@
// Interface of the pixel request channel.
`default_nettype none

interface iohist_pixel_if;
	logic valid;
	logic ready;
	logic signed [iohist_pkg::GRAD_W-1:0] gradient_x;
	logic signed [iohist_pkg::GRAD_W-1:0] gradient_y;
	logic row_end;
	logic frame_end;

	modport source (output valid, gradient_x, gradient_y, row_end, frame_end, input ready);
	modport sink (input valid, gradient_x, gradient_y, row_end, frame_end, output ready);
endinterface

`default_nettype wire

@@ hdl/iohist_result_if.sv @@
// Interface of the result request channel.
`default_nettype none

interface iohist_result_if;
	logic valid;
	logic ready;
	logic [iohist_pkg::SUM_W-1:0] sum_bin0;
	logic [iohist_pkg::SUM_W-1:0] sum_bin1;
	logic [iohist_pkg::SUM_W-1:0] sum_bin2;
	logic [iohist_pkg::SUM_W-1:0] sum_bin3;
	logic [iohist_pkg::SUM_W-1:0] sum_bin4;
	logic [iohist_pkg::SUM_W-1:0] sum_bin5;
	logic [iohist_pkg::SUM_W-1:0] sum_bin6;
	logic [iohist_pkg::SUM_W-1:0] sum_bin7;
	logic [iohist_pkg::SUM_W-1:0] sum_bin8;
	logic [iohist_pkg::BIN_W-1:0] chosen_bin;
	logic [iohist_pkg::MAG_W-1:0] magnitude;
	logic width_error;

	modport source (
		output valid, sum_bin0, sum_bin1, sum_bin2, sum_bin3, sum_bin4, sum_bin5,
			sum_bin6, sum_bin7, sum_bin8, chosen_bin, magnitude, width_error,
		input ready
	);
	modport sink (
		input valid, sum_bin0, sum_bin1, sum_bin2, sum_bin3, sum_bin4, sum_bin5,
			sum_bin6, sum_bin7, sum_bin8, chosen_bin, magnitude, width_error,
		output ready
	);
endinterface

`default_nettype wire

@@ hdl/iohist_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module iohist_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input wire logic clk,
	input wire logic wr_en,
	input wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input wire logic [WIDTH-1:0] wr_data,
	input wire logic rd_en,
	input wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

@@ hdl/iohist_grad.sv @@
// Gradient unit: iterative magnitude square root and orientation bin search.
`default_nettype none

module iohist_grad #(
	parameter int MAG_FRAC_BITS = iohist_pkg::MAG_FRAC_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire iohist_pkg::iohist_grad_ctrl_t ctrl,
	input wire logic signed [iohist_pkg::GRAD_W-1:0] gradient_x,
	input wire logic signed [iohist_pkg::GRAD_W-1:0] gradient_y,
	output logic [iohist_pkg::BIN_W-1:0] bin,
	output logic [iohist_pkg::MAG_W-1:0] magnitude
);

	localparam int GW = iohist_pkg::GRAD_W;
	localparam int ROOT_BITS = iohist_pkg::SQ_W / 2 + MAG_FRAC_BITS;
	localparam int RAD_W = 2 * ROOT_BITS;
	localparam int REM_W = ROOT_BITS + 2;
	localparam int RND_W = ROOT_BITS + 1;
	localparam int SAT_W = ROOT_BITS + 16;
	localparam int THR_IDX_W = $clog2(iohist_pkg::NUM_THR + 1);
	localparam int THR_SEL_W = $clog2(iohist_pkg::NUM_THR);
	localparam logic [THR_IDX_W-1:0] THR_END = THR_IDX_W'(iohist_pkg::NUM_THR);

	logic signed [GW-1:0] gx_q;
	logic signed [GW-1:0] gy_q;
	logic signed [GW:0] gxn_q;
	logic signed [GW:0] gyn_q;
	logic [iohist_pkg::SQ_W-1:0] sqx_s1;
	logic [iohist_pkg::SQ_W-1:0] sqy_s1;
	logic [RAD_W-1:0] rad_q;
	logic [REM_W-1:0] rem_q;
	logic [ROOT_BITS-1:0] root_q;
	logic signed [iohist_pkg::PROD_W-1:0] prod_q;
	logic prod_v_q;
	logic [THR_IDX_W-1:0] thr_idx_q;
	logic [iohist_pkg::BIN_W-1:0] cnt_q;
	logic [iohist_pkg::BIN_W-1:0] bin_q;
	logic [iohist_pkg::MAG_W-1:0] mag_q;

	logic signed [GW:0] gx_ext;
	logic signed [GW:0] gy_ext;
	logic signed [iohist_pkg::SQ_W-1:0] gxx;
	logic signed [iohist_pkg::SQ_W-1:0] gyy;
	logic [iohist_pkg::SQ_W-1:0] sq_sum;
	logic [REM_W-1:0] cand;
	logic [REM_W-1:0] trial;
	logic rem_up;
	logic [RND_W-1:0] rounded;
	logic [SAT_W-1:0] rounded_ext;
	logic [iohist_pkg::MAG_W-1:0] mag_sat;
	logic signed [iohist_pkg::ANGLE_CMP_W-1:0] gy_scaled;
	logic signed [iohist_pkg::ANGLE_CMP_W-1:0] prod_ext;
	logic [iohist_pkg::BIN_W-1:0] bin_final;

	assign gx_ext = (GW + 1)'(gradient_x);
	assign gy_ext = (GW + 1)'(gradient_y);
	assign gxx = gx_q * gx_q;
	assign gyy = gy_q * gy_q;
	assign sq_sum = sqx_s1 + sqy_s1;

	assign cand = {rem_q[ROOT_BITS-1:0], rad_q[RAD_W-1 -: 2]};
	assign trial = {root_q, 2'b01};
	assign rem_up = rem_q > REM_W'(root_q);
	assign rounded = RND_W'(root_q) + RND_W'(rem_up);
	assign rounded_ext = SAT_W'(rounded);
	assign mag_sat = (rounded_ext > SAT_W'(iohist_pkg::MAG_MAX)) ?
		iohist_pkg::MAG_MAX : rounded_ext[iohist_pkg::MAG_W-1:0];

	assign gy_scaled = iohist_pkg::ANGLE_CMP_W'(gyn_q) <<< iohist_pkg::TAN_FRAC;
	assign prod_ext = iohist_pkg::ANGLE_CMP_W'(prod_q);

	always_comb begin
		if (gx_q != '0) begin
			bin_final = cnt_q;
		end else if (gy_q == '0) begin
			bin_final = iohist_pkg::BIN_FLAT;
		end else if (gy_q[GW-1]) begin
			bin_final = iohist_pkg::BIN_DOWN;
		end else begin
			bin_final = iohist_pkg::BIN_UP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_idx_q <= '0;
			prod_v_q <= 1'b0;
			cnt_q <= '0;
		end else if (ctrl.load) begin
			thr_idx_q <= '0;
			prod_v_q <= 1'b0;
			cnt_q <= '0;
		end else if (ctrl.root) begin
			prod_v_q <= (thr_idx_q < THR_END);
			if (thr_idx_q < THR_END) begin
				thr_idx_q <= thr_idx_q + 1'b1;
			end
			if (prod_v_q && (gy_scaled > prod_ext)) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			gx_q <= gradient_x;
			gy_q <= gradient_y;
			gxn_q <= gradient_x[GW-1] ? -gx_ext : gx_ext;
			gyn_q <= gradient_x[GW-1] ? -gy_ext : gy_ext;
		end
		if (ctrl.square) begin
			sqx_s1 <= gxx;
			sqy_s1 <= gyy;
		end
		if (ctrl.sum) begin
			rad_q <= RAD_W'(sq_sum) << (2 * MAG_FRAC_BITS);
			rem_q <= '0;
			root_q <= '0;
		end
		if (ctrl.root) begin
			rad_q <= rad_q << 2;
			if (cand >= trial) begin
				rem_q <= cand - trial;
				root_q <= {root_q[ROOT_BITS-2:0], 1'b1};
			end else begin
				rem_q <= cand;
				root_q <= {root_q[ROOT_BITS-2:0], 1'b0};
			end
			prod_q <= gxn_q * iohist_pkg::THRESH[thr_idx_q[THR_SEL_W-1:0]];
		end
		if (ctrl.round) begin
			mag_q <= mag_sat;
			bin_q <= bin_final;
		end
	end

	assign bin = bin_q;
	assign magnitude = mag_q;

`ifndef NO_ASSERTIONS
	a_mag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.round |=> ((mag_q == '0) == ((gx_q == '0) && (gy_q == '0))))
		else $error("magnitude zero does not match zero gradients");
`endif

endmodule

`default_nettype wire

@@ hdl/iohist_accum.sv @@
// Row accumulator: running row sums, column tracking and the previous-row store.
`default_nettype none

module iohist_accum #(
	parameter int MAX_WIDTH = iohist_pkg::MAX_WIDTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire iohist_pkg::iohist_acc_ctrl_t ctrl,
	input wire logic row_end,
	input wire logic frame_end,
	input wire logic [iohist_pkg::BIN_W-1:0] bin,
	input wire logic [iohist_pkg::MAG_W-1:0] magnitude,
	output iohist_pkg::iohist_sums_t sums,
	output logic width_error
);

	localparam int COL_W = $clog2(MAX_WIDTH + 1);
	localparam int ADDR_W = $clog2(MAX_WIDTH);
	localparam int NB = iohist_pkg::NUM_BINS;
	localparam logic [COL_W-1:0] COL_LIMIT = COL_W'(MAX_WIDTH);

	logic [COL_W-1:0] col_q;
	logic first_q;
	iohist_pkg::iohist_sums_t running_q;

	iohist_pkg::iohist_sums_t above;
	iohist_pkg::iohist_sums_t totals;
	iohist_pkg::iohist_sums_t rd_data;
	logic err;

	assign err = col_q >= COL_LIMIT;

	iohist_ram #(
		.WIDTH($bits(iohist_pkg::iohist_sums_t)),
		.DEPTH(MAX_WIDTH)
	) u_row_store (
		.clk(clk),
		.wr_en(ctrl.total && !err),
		.wr_addr(col_q[ADDR_W-1:0]),
		.wr_data(totals),
		.rd_en(ctrl.read),
		.rd_addr(col_q[ADDR_W-1:0]),
		.rd_data(rd_data)
	);

	always_comb begin
		for (int b = 0; b < NB; b++) begin
			above[b] = (first_q || err) ? '0 : rd_data[b];
			totals[b] = iohist_pkg::sat_add(above[b], running_q[b]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			first_q <= 1'b1;
			running_q <= '0;
		end else if (ctrl.accum) begin
			for (int b = 0; b < NB; b++) begin
				if (bin == iohist_pkg::BIN_W'(b)) begin
					running_q[b] <= iohist_pkg::sat_add(running_q[b],
						iohist_pkg::SUM_W'(magnitude));
				end
			end
		end else if (ctrl.total) begin
			if (row_end || frame_end) begin
				running_q <= '0;
				col_q <= '0;
				first_q <= frame_end;
			end else if (!err) begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	assign sums = totals;
	assign width_error = err;

`ifndef NO_ASSERTIONS
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= COL_LIMIT)
		else $error("column index beyond the row store");
	a_row_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.total && (row_end || frame_end)) |=> ((col_q == '0) && (running_q == '0)))
		else $error("row end did not restart the row");
`endif

endmodule

`default_nettype wire

@@ hdl/integral_orientation_histogram.sv @@
// Top level of the integral orientation histogram: sequencer and result register.
// A pixel is processed to the end before the next one is taken; the square root resolves
// one magnitude bit per cycle.
// A new pixel is taken while the previous result still waits in the output register.
// Reset clears the row sums, the column index and the sequencer; the row store is not cleared.
`default_nettype none

module integral_orientation_histogram #(
	parameter int MAX_WIDTH = iohist_pkg::MAX_WIDTH_DEF,
	parameter int MAG_FRAC_BITS = iohist_pkg::MAG_FRAC_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	iohist_pixel_if.sink pixel,
	iohist_result_if.source result
);

	localparam int ROOT_BITS = iohist_pkg::SQ_W / 2 + MAG_FRAC_BITS;
	localparam int STEP_W = $clog2(ROOT_BITS);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(ROOT_BITS - 1);

	iohist_pkg::iohist_state_t state_q;
	iohist_pkg::iohist_state_t state_d;
	logic [STEP_W-1:0] step_q;
	logic row_end_q;
	logic frame_end_q;

	logic out_valid_q;
	iohist_pkg::iohist_sums_t sums_q;
	logic [iohist_pkg::BIN_W-1:0] bin_out_q;
	logic [iohist_pkg::MAG_W-1:0] mag_out_q;
	logic err_out_q;

	iohist_pkg::iohist_grad_ctrl_t gctrl;
	iohist_pkg::iohist_acc_ctrl_t actrl;
	logic accept;
	logic out_free;
	logic out_load;

	iohist_pkg::iohist_sums_t sums;
	logic [iohist_pkg::BIN_W-1:0] bin;
	logic [iohist_pkg::MAG_W-1:0] magnitude;
	logic width_error;

	assign out_free = !out_valid_q || result.ready;

	iohist_grad #(
		.MAG_FRAC_BITS(MAG_FRAC_BITS)
	) u_grad (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl(gctrl),
		.gradient_x(pixel.gradient_x),
		.gradient_y(pixel.gradient_y),
		.bin(bin),
		.magnitude(magnitude)
	);

	iohist_accum #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_accum (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl(actrl),
		.row_end(row_end_q),
		.frame_end(frame_end_q),
		.bin(bin),
		.magnitude(magnitude),
		.sums(sums),
		.width_error(width_error)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			iohist_pkg::S_IDLE: begin
				if (pixel.valid) state_d = iohist_pkg::S_SQUARE;
			end
			iohist_pkg::S_SQUARE: state_d = iohist_pkg::S_SUM;
			iohist_pkg::S_SUM: state_d = iohist_pkg::S_ROOT;
			iohist_pkg::S_ROOT: begin
				if (step_q == STEP_LAST) state_d = iohist_pkg::S_ROUND;
			end
			iohist_pkg::S_ROUND: state_d = iohist_pkg::S_ACCUM;
			iohist_pkg::S_ACCUM: state_d = iohist_pkg::S_TOTAL;
			iohist_pkg::S_TOTAL: begin
				if (out_free) state_d = iohist_pkg::S_IDLE;
			end
			default: state_d = iohist_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		accept = pixel.valid && (state_q == iohist_pkg::S_IDLE);
		gctrl.load = accept;
		gctrl.square = (state_q == iohist_pkg::S_SQUARE);
		gctrl.sum = (state_q == iohist_pkg::S_SUM);
		gctrl.root = (state_q == iohist_pkg::S_ROOT);
		gctrl.round = (state_q == iohist_pkg::S_ROUND);
		actrl.read = accept;
		actrl.accum = (state_q == iohist_pkg::S_ACCUM);
		out_load = (state_q == iohist_pkg::S_TOTAL) && out_free;
		actrl.total = out_load;
	end

	assign pixel.ready = (state_q == iohist_pkg::S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iohist_pkg::S_IDLE;
			step_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == iohist_pkg::S_SUM) begin
				step_q <= '0;
			end else if (state_q == iohist_pkg::S_ROOT) begin
				step_q <= step_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			row_end_q <= pixel.row_end;
			frame_end_q <= pixel.frame_end;
		end
		if (out_load) begin
			sums_q <= sums;
			bin_out_q <= bin;
			mag_out_q <= magnitude;
			err_out_q <= width_error;
		end
	end

	assign result.valid = out_valid_q;
	assign result.sum_bin0 = sums_q[0];
	assign result.sum_bin1 = sums_q[1];
	assign result.sum_bin2 = sums_q[2];
	assign result.sum_bin3 = sums_q[3];
	assign result.sum_bin4 = sums_q[4];
	assign result.sum_bin5 = sums_q[5];
	assign result.sum_bin6 = sums_q[6];
	assign result.sum_bin7 = sums_q[7];
	assign result.sum_bin8 = sums_q[8];
	assign result.chosen_bin = bin_out_q;
	assign result.magnitude = mag_out_q;
	assign result.width_error = err_out_q;

`ifndef NO_ASSERTIONS
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == iohist_pkg::S_TOTAL))
		else $error("result appeared without a finished pixel");
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == iohist_pkg::S_ROOT) |-> (step_q <= STEP_LAST))
		else $error("square root step count overran");
`endif

endmodule

`default_nettype wire

@@ test/iohist_integral_checker.sv @@
// Checker that predicts each pixel's integral orientation histogram and compares the results.

module iohist_integral_checker #(
	parameter int MAX_WIDTH = iohist_pkg::MAX_WIDTH_DEF,
	parameter int MAG_FRAC_BITS = iohist_pkg::MAG_FRAC_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	iohist_pixel_if pixel,
	iohist_result_if result,
	output int hist_pending,
	output int mismatches
);

	import iohist_pkg::*;

	localparam iohist_sum_t SUM_TOP = '1;
	localparam int PRINT_LIMIT = 100;

	typedef struct {
		iohist_sums_t sums;
		logic [BIN_W-1:0] bin;
		logic [MAG_W-1:0] mag;
		logic werr;
	} pixel_hist_t;

	iohist_sum_t row_above [MAX_WIDTH][NUM_BINS];
	iohist_sum_t row_run [NUM_BINS];
	int col_idx;
	logic first_row;
	pixel_hist_t hist_due [$];
	int result_no = 0;
	int fail_count = 0;

	assign mismatches = fail_count;

	task automatic report_mismatch(input string msg);
		if (fail_count < PRINT_LIMIT) begin
			$display("%0t mismatch: %s", $time, msg);
		end
		fail_count++;
	endtask

	function automatic iohist_sum_t add_clamped(input iohist_sum_t a, input iohist_sum_t b);
		if (a > SUM_TOP - b) begin
			return SUM_TOP;
		end
		return a + b;
	endfunction

	function automatic logic [MAG_W-1:0] round_root(input longint unsigned v);
		longint unsigned root;
		longint unsigned trial;
		root = 0;
		for (int i = 24; i >= 0; i--) begin
			trial = root | (64'd1 << i);
			if (trial * trial <= v) begin
				root = trial;
			end
		end
		// Rounds half up: the exact root reaches root + 0.5 once the remainder exceeds root.
		if (v - root * root > root) begin
			root = root + 1;
		end
		if (root > MAG_MAX) begin
			return MAG_MAX;
		end
		return root[MAG_W-1:0];
	endfunction

	function automatic logic [BIN_W-1:0] orient_bin(input longint x, input longint y);
		logic [BIN_W-1:0] k;
		k = '0;
		if (x == 0) begin
			return (y > 0) ? BIN_UP : ((y < 0) ? BIN_DOWN : BIN_FLAT);
		end
		if (x < 0) begin
			x = -x;
			y = -y;
		end
		for (int j = 0; j < NUM_THR; j++) begin
			if ((y <<< TAN_FRAC) > x * longint'(THRESH[j])) begin
				k++;
			end
		end
		return k;
	endfunction

	function automatic pixel_hist_t predict_pixel(
		input logic signed [GRAD_W-1:0] gx,
		input logic signed [GRAD_W-1:0] gy,
		input logic re,
		input logic fe
	);
		pixel_hist_t h;
		iohist_sum_t above;
		longint sq;
		logic over;
		sq = longint'(gx) * longint'(gx) + longint'(gy) * longint'(gy);
		h.mag = round_root(sq << (2 * MAG_FRAC_BITS));
		h.bin = orient_bin(gx, gy);
		over = col_idx >= MAX_WIDTH;
		h.werr = over;
		for (int b = 0; b < NUM_BINS; b++) begin
			if (h.bin == b) begin
				row_run[b] = add_clamped(row_run[b], iohist_sum_t'(h.mag));
			end
			above = (!first_row && !over) ? row_above[col_idx][b] : '0;
			h.sums[b] = add_clamped(above, row_run[b]);
			if (!over) begin
				row_above[col_idx][b] = h.sums[b];
			end
		end
		if (re || fe) begin
			for (int b = 0; b < NUM_BINS; b++) begin
				row_run[b] = '0;
			end
			col_idx = 0;
			first_row = fe;
		end else if (!over) begin
			col_idx++;
		end
		return h;
	endfunction

	task automatic check_result();
		pixel_hist_t want;
		iohist_sums_t got;
		got = {result.sum_bin8, result.sum_bin7, result.sum_bin6, result.sum_bin5,
			result.sum_bin4, result.sum_bin3, result.sum_bin2, result.sum_bin1, result.sum_bin0};
		result_no++;
		if (hist_due.size() == 0) begin
			report_mismatch($sformatf("result %0d arrived with no pixel request waiting", result_no));
			return;
		end
		want = hist_due.pop_front();
		for (int b = 0; b < NUM_BINS; b++) begin
			if (got[b] !== want.sums[b]) begin
				report_mismatch($sformatf("result %0d sum_bin%0d: got %0d, expected %0d",
					result_no, b, got[b], want.sums[b]));
			end
		end
		if (result.chosen_bin !== want.bin) begin
			report_mismatch($sformatf("result %0d chosen_bin: got %0d, expected %0d",
				result_no, result.chosen_bin, want.bin));
		end
		if (result.magnitude !== want.mag) begin
			report_mismatch($sformatf("result %0d magnitude: got %0d, expected %0d",
				result_no, result.magnitude, want.mag));
		end
		if (result.width_error !== want.werr) begin
			report_mismatch($sformatf("result %0d width_error: got %0b, expected %0b",
				result_no, result.width_error, want.werr));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < NUM_BINS; b++) begin
				row_run[b] = '0;
			end
			col_idx = 0;
			first_row = 1'b1;
			hist_due.delete();
			hist_pending <= 0;
		end else begin
			if (pixel.valid && pixel.ready) begin
				hist_due.push_back(predict_pixel(pixel.gradient_x, pixel.gradient_y,
					pixel.row_end, pixel.frame_end));
			end
			if (result.valid && result.ready) begin
				check_result();
			end
			hist_pending <= hist_due.size();
		end
	end

endmodule

@@ test/tb_top.sv @@
// Top of the orientation histogram testbench: clock, reset, pixel stimulus and verdict.

module tb_top;

	import iohist_pkg::*;

	localparam int ROW_LIMIT = MAX_WIDTH_DEF;
	localparam int LONG_ROW = ROW_LIMIT + 3;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 40;

	logic clk = 1'b0;
	logic arst_n;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;
	int pixels_sent = 0;
	int hist_pending;
	int mismatches;

	// Mirror of the row position, so that no row reads a store column that was never written.
	int gen_col = 0;
	logic gen_first = 1'b1;
	int gen_written = 0;

	iohist_pixel_if pixel ();
	iohist_result_if result ();

	integral_orientation_histogram dut (
		.clk(clk),
		.arst_n(arst_n),
		.pixel(pixel),
		.result(result)
	);

	iohist_integral_checker hist_check (
		.clk(clk),
		.arst_n(arst_n),
		.pixel(pixel),
		.result(result),
		.hist_pending(hist_pending),
		.mismatches(mismatches)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		result.ready <= arst_n && ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if ((pixel.valid && pixel.ready) || (result.valid && result.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no request accepted for %0d cycles", quiet_cycles);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic send_pixel(input int gx, input int gy, input logic re, input logic fe);
		while ($urandom_range(99) < send_idle_pct) begin
			pixel.valid <= 1'b0;
			@(posedge clk);
		end
		pixel.gradient_x <= GRAD_W'(gx);
		pixel.gradient_y <= GRAD_W'(gy);
		pixel.row_end <= re;
		pixel.frame_end <= fe;
		pixel.valid <= 1'b1;
		@(posedge clk);
		while (!pixel.ready) begin
			@(posedge clk);
		end
		pixels_sent++;
		if (gen_col < ROW_LIMIT && gen_col + 1 > gen_written) begin
			gen_written = gen_col + 1;
		end
		if (re || fe) begin
			gen_col = 0;
			gen_first = fe;
		end else if (gen_col < ROW_LIMIT) begin
			gen_col++;
		end
	endtask

	task automatic drain_pending();
		pixel.valid <= 1'b0;
		@(posedge clk);
		while (hist_pending != 0) begin
			@(posedge clk);
		end
	endtask

	function automatic int pick_gradient();
		case ($urandom_range(9))
			0: begin
				return 0;
			end
			1: begin
				return int'($urandom_range(6)) - 3;
			end
			2: begin
				return $urandom_range(1) ? 1020 : -1020;
			end
			default: begin
				return int'($urandom_range(2040)) - 1020;
			end
		endcase
	endfunction

	task automatic send_frame(input int width, input int rows);
		logic re;
		logic fe;
		for (int r = 0; r < rows; r++) begin
			for (int c = 0; c < width; c++) begin
				re = (c == width - 1);
				fe = re && (r == rows - 1);
				if (fe) begin
					re = $urandom_range(1);
				end
				if ($urandom_range(24) == 0) begin
					re = $urandom_range(1);
					fe = ($urandom_range(3) == 0);
				end
				// A later row must end before it passes the widest row stored so far.
				if (!re && !fe && !gen_first && gen_col + 1 < ROW_LIMIT
						&& gen_col + 1 >= gen_written) begin
					re = 1'b1;
				end
				send_pixel(pick_gradient(), pick_gradient(), re, fe);
			end
		end
	endtask

	task automatic run_phase(input int quota);
		int start;
		int width;
		start = pixels_sent;
		while (pixels_sent - start < quota) begin
			width = ($urandom_range(7) == 0) ? $urandom_range(48, 13) : $urandom_range(12, 1);
			send_frame(width, $urandom_range(6, 1));
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		pixel.valid <= 1'b0;
		pixel.gradient_x <= '0;
		pixel.gradient_y <= '0;
		pixel.row_end <= 1'b0;
		pixel.frame_end <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// One pixel in each of bins 0 to 7 on the first row after reset; bin 8 opens the second row.
		send_pixel(100, -500, 1'b0, 1'b0);
		send_pixel(100, -200, 1'b0, 1'b0);
		send_pixel(100, -100, 1'b0, 1'b0);
		send_pixel(100, -30, 1'b0, 1'b0);
		send_pixel(100, 0, 1'b0, 1'b0);
		send_pixel(100, 30, 1'b0, 1'b0);
		send_pixel(100, 100, 1'b0, 1'b0);
		send_pixel(100, 200, 1'b1, 1'b0);
		// Second row adds the stored row above, with zero and extreme gradients.
		send_pixel(100, 500, 1'b0, 1'b0);
		send_pixel(-100, 500, 1'b0, 1'b0);
		send_pixel(0, 0, 1'b0, 1'b0);
		send_pixel(0, 7, 1'b0, 1'b0);
		send_pixel(0, -7, 1'b0, 1'b0);
		send_pixel(1020, 1020, 1'b0, 1'b0);
		send_pixel(-1020, -1020, 1'b0, 1'b0);
		send_pixel(1020, -1020, 1'b1, 1'b0);
		// Shorter third row closed by a frame end alone.
		send_pixel(-1020, 1020, 1'b0, 1'b0);
		send_pixel(0, 1020, 1'b0, 1'b0);
		send_pixel(0, -1020, 1'b0, 1'b0);
		send_pixel(-1, 0, 1'b0, 1'b0);
		send_pixel(1, -1, 1'b0, 1'b0);
		send_pixel(-1020, 0, 1'b0, 1'b1);
		// Fresh frame whose only row ends with both marks.
		send_pixel(1020, 0, 1'b0, 1'b0);
		send_pixel(-5, 3, 1'b1, 1'b1);
		drain_pending();

		// A first row longer than the store raises the width error on its tail.
		for (int c = 0; c < LONG_ROW; c++) begin
			send_pixel(pick_gradient(), pick_gradient(), 1'b0, c == LONG_ROW - 1);
		end
		run_phase(150);
		drain_pending();

		send_idle_pct = 87;
		recv_stall_pct = 0;
		run_phase(190);
		drain_pending();

		send_idle_pct = 0;
		recv_stall_pct = 87;
		run_phase(190);
		drain_pending();

		send_idle_pct = 14;
		recv_stall_pct = 14;
		run_phase(190);
		drain_pending();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && hist_pending == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
